@@ sv/pvo_pkg.sv @@
// Package for the polyline vertex offset block.
// Fixed widths of the distance register and of the serial arithmetic datapath.
// No dependencies.
package pvo_pkg;

    localparam int DIST_WIDTH = 32;   // offset_distance, signed Q16.16
    localparam int UNIT_SHIFT = 30;   // unit vectors are Q2.30
    localparam int UNIT_WIDTH = 32;   // unit component magnitude
    localparam int NORM_WIDTH = 31;   // normalized magnitude, top bit at 30
    localparam int MAC_WIDTH  = 64;   // product / radicand width
    localparam int NUM_WIDTH  = 62;   // dividend width of the unit division
    localparam int OFF_WIDTH  = 34;   // offset magnitude after rounding
    localparam int CNT_WIDTH  = 6;    // serial step counter

endpackage

@@ sv/pvo_ifs.sv @@
// Valid/ready channel interfaces for the polyline vertex offset block.
// Vertex request channel and offset result channel; no dependencies.
interface pvo_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic                final_vertex;

    modport source (output valid, output vx, output vy, output final_vertex, input ready);
    modport sink   (input valid, input vx, input vy, input final_vertex, output ready);
endinterface

interface pvo_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic                degenerate;
    logic                end_of_line;

    modport source (output valid, output ox, output oy, output degenerate,
                    output end_of_line, input ready);
    modport sink   (input valid, input ox, input oy, input degenerate,
                    input end_of_line, output ready);
endinterface

@@ sv/polyline_vertex_offset.sv @@
// Polyline vertex offset along bisector normals, bit-serial datapath.
// Uses pvo_pkg and the channel interfaces in pvo_ifs.sv.
//
//  channel    dir  handshake          payload
//  i_vtx      in   valid/ready        vx, vy, final_vertex
//  o_res      out  valid/ready        ox, oy, degenerate, end_of_line
//  i_cfg_*    in   write enable only  offset_distance
//
// One vertex request is taken at a time; ready is high only while the sequencer is idle.
// Each normalization runs the normalizing shift, then serial squares, a 2-bit-per-step
// root and two restoring divides. Each non-degenerate result adds serial offset multiplies
// and placement.
// An inner vertex runs three normalizations; a final vertex adds one more.
// A stalled output register holds the sequencer at its next result; reset is synchronous.
module polyline_vertex_offset
    import pvo_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DIST_WIDTH-1:0] i_cfg_data,
    pvo_in_if.sink                i_vtx,
    pvo_out_if.source             o_res
);

    localparam int W  = COORD_WIDTH;
    localparam int MW = (W > UNIT_WIDTH) ? W : UNIT_WIDTH;
    localparam int PW = ((W > OFF_WIDTH) ? W : OFF_WIDTH) + 1;
    localparam logic [W-1:0] CSIGN = {1'b1, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIVX  = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_UDONE = 4'd7;
    localparam logic [3:0] S_MOX   = 4'd8;
    localparam logic [3:0] S_MOY   = 4'd9;
    localparam logic [3:0] S_PLACE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_END   = 4'd12;

    // what the current normalization is for
    localparam logic [2:0] J_A   = 3'd0;  // incoming segment of an inner vertex
    localparam logic [2:0] J_B   = 3'd1;  // outgoing segment of an inner vertex
    localparam logic [2:0] J_P   = 3'd2;  // result for the prior vertex
    localparam logic [2:0] J_C   = 3'd3;  // result for the final vertex
    localparam logic [2:0] J_ONE = 3'd4;  // one-point line

    function automatic logic [W:0] f_diff(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] ba;
        logic [W-1:0] bb;
        ba = a ^ CSIGN;
        bb = b ^ CSIGN;
        if (ba >= bb) f_diff = {1'b0, ba - bb};
        else          f_diff = {1'b1, bb - ba};
    endfunction

    function automatic logic [UNIT_WIDTH:0] f_sadd(input logic an, input logic [UNIT_WIDTH-1:0] am,
                                                    input logic bn, input logic [UNIT_WIDTH-1:0] bm);
        logic                  rn;
        logic [UNIT_WIDTH-1:0] rm;
        if (an == bn)      begin rn = an; rm = am + bm; end
        else if (am >= bm) begin rn = an; rm = am - bm; end
        else               begin rn = bn; rm = bm - am; end
        if (rm == '0) rn = 1'b0;
        f_sadd = {rn, rm};
    endfunction

    function automatic logic [W-1:0] f_place(input logic [W-1:0] raw, input logic neg,
                                             input logic [OFF_WIDTH-1:0] mag);
        logic [PW-1:0] b;
        logic [PW-1:0] m;
        logic [PW-1:0] s;
        logic [PW-1:0] cmax;
        b    = PW'(raw ^ CSIGN);
        m    = PW'(mag);
        cmax = PW'({W{1'b1}});
        if (!neg) begin
            s = b + m;
            if (s > cmax) s = cmax;
        end else begin
            s = (m > b) ? '0 : b - m;
        end
        f_place = s[W-1:0] ^ CSIGN;
    endfunction

    logic [3:0]            r_state, n_state;
    logic [2:0]            r_job, n_job;
    logic [CNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic [1:0]            r_seen, n_seen;
    logic                  r_fin, n_fin;
    logic [DIST_WIDTH-1:0] r_dist, n_dist;
    logic [W-1:0]          r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [W-1:0]          r_pri_x, n_pri_x, r_pri_y, n_pri_y;
    logic [W-1:0]          r_old_x, n_old_x, r_old_y, n_old_y;
    logic [MW-1:0]         r_mx, n_mx, r_my, n_my;
    logic                  r_nx, n_nx, r_ny, n_ny, r_uzero, n_uzero;
    logic [MAC_WIDTH-1:0]  r_mc, n_mc, r_acc, n_acc, r_root, n_root;
    logic [UNIT_WIDTH-1:0] r_mp, n_mp;
    logic [NUM_WIDTH-1:0]  r_num, n_num;
    logic [UNIT_WIDTH-1:0] r_rem, n_rem, r_quo, n_quo, r_len, n_len;
    logic [UNIT_WIDTH-1:0] r_ux, n_ux, r_uy, n_uy, r_sx, n_sx, r_sy, n_sy;
    logic                  r_sxn, n_sxn, r_syn, n_syn;
    logic [OFF_WIDTH-1:0]  r_offx, n_offx, r_offy, n_offy;
    logic [W-1:0]          r_stg_x, n_stg_x, r_stg_y, n_stg_y;
    logic                  r_stg_deg, n_stg_deg, r_stg_eol, n_stg_eol;
    logic                  r_ov, n_ov, r_odeg, n_odeg, r_oeol, n_oeol;
    logic [W-1:0]          r_ox, n_ox, r_oy, n_oy;

    logic                  ld_en, ld_xn, ld_yn;
    logic [MW-1:0]         ld_xm, ld_ym;
    logic [W:0]            d_cp_x, d_cp_y, d_in_x, d_in_y, d_po_x, d_po_y;
    logic [MW-1:0]         top;
    logic                  dneg, ex_n, ey_n;
    logic [UNIT_WIDTH-1:0] dmag;
    logic [MAC_WIDTH-1:0]  bitv, trial;
    logic [UNIT_WIDTH:0]   tdiv, sa_x, sa_y;
    logic [MAC_WIDTH:0]    rnd;
    logic                  out_free;
    logic [W-1:0]          raw_x, raw_y;

    assign d_cp_x = f_diff(r_cur_x, r_pri_x);
    assign d_cp_y = f_diff(r_cur_y, r_pri_y);
    assign d_po_x = f_diff(r_pri_x, r_old_x);
    assign d_po_y = f_diff(r_pri_y, r_old_y);
    assign d_in_x = f_diff(i_vtx.vx, r_pri_x);
    assign d_in_y = f_diff(i_vtx.vy, r_pri_y);
    assign top    = (r_mx > r_my) ? r_mx : r_my;
    assign dneg   = r_dist[DIST_WIDTH-1];
    assign dmag   = dneg ? (~r_dist + 1'b1) : r_dist;
    assign ex_n   = r_nx & (r_ux != '0);
    assign ey_n   = r_ny & (r_uy != '0);
    assign bitv   = MAC_WIDTH'(1) << {r_cnt[4:0], 1'b0};
    assign trial  = r_root + bitv;
    assign tdiv   = {r_rem, r_num[NUM_WIDTH-1]};
    assign sa_x   = f_sadd(r_sxn, r_sx, ex_n, r_ux);
    assign sa_y   = f_sadd(r_syn, r_sy, ey_n, r_uy);
    assign out_free = !r_ov || o_res.ready;
    assign raw_x  = (r_job == J_C) ? r_cur_x : r_pri_x;
    assign raw_y  = (r_job == J_C) ? r_cur_y : r_pri_y;

    assign i_vtx.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.ox          = r_ox;
    assign o_res.oy          = r_oy;
    assign o_res.degenerate  = r_odeg;
    assign o_res.end_of_line = r_oeol;

    always_comb begin
        n_state = r_state;  n_job = r_job;  n_cnt = r_cnt;  n_seen = r_seen;
        n_fin = r_fin;      n_dist = r_dist;
        n_cur_x = r_cur_x;  n_cur_y = r_cur_y;  n_pri_x = r_pri_x;  n_pri_y = r_pri_y;
        n_old_x = r_old_x;  n_old_y = r_old_y;
        n_mx = r_mx;  n_my = r_my;  n_nx = r_nx;  n_ny = r_ny;  n_uzero = r_uzero;
        n_mc = r_mc;  n_acc = r_acc;  n_root = r_root;  n_mp = r_mp;
        n_num = r_num;  n_rem = r_rem;  n_quo = r_quo;  n_len = r_len;
        n_ux = r_ux;  n_uy = r_uy;  n_sx = r_sx;  n_sy = r_sy;  n_sxn = r_sxn;  n_syn = r_syn;
        n_offx = r_offx;  n_offy = r_offy;
        n_stg_x = r_stg_x;  n_stg_y = r_stg_y;  n_stg_deg = r_stg_deg;  n_stg_eol = r_stg_eol;
        n_ov = r_ov;  n_ox = r_ox;  n_oy = r_oy;  n_odeg = r_odeg;  n_oeol = r_oeol;
        ld_en = 1'b0;  ld_xn = 1'b0;  ld_yn = 1'b0;  ld_xm = '0;  ld_ym = '0;
        rnd = '0;

        if (i_cfg_we) n_dist = i_cfg_data;
        if (r_ov && o_res.ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_vtx.valid) begin
                    n_cur_x = i_vtx.vx;
                    n_cur_y = i_vtx.vy;
                    n_fin   = i_vtx.final_vertex;
                    if (r_seen == 2'd0) begin
                        if (i_vtx.final_vertex) begin
                            n_stg_x = '0;  n_stg_y = '0;
                            n_stg_deg = 1'b0;  n_stg_eol = 1'b1;
                            n_job = J_ONE;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_END;
                        end
                    end else if (r_seen == 2'd1) begin
                        ld_en = 1'b1;
                        ld_xn = d_in_x[W];  ld_xm = MW'(d_in_x[W-1:0]);
                        ld_yn = d_in_y[W];  ld_ym = MW'(d_in_y[W-1:0]);
                        n_job = J_P;
                    end else begin
                        ld_en = 1'b1;
                        ld_xn = d_po_x[W];  ld_xm = MW'(d_po_x[W-1:0]);
                        ld_yn = d_po_y[W];  ld_ym = MW'(d_po_y[W-1:0]);
                        n_job = J_A;
                    end
                end
            end
            S_NORM: begin
                if (top[MW-1:NORM_WIDTH] != '0) begin
                    n_mx = r_mx >> 1;
                    n_my = r_my >> 1;
                end else if (!top[UNIT_SHIFT]) begin
                    n_mx = r_mx << 1;
                    n_my = r_my << 1;
                end else begin
                    n_mc  = MAC_WIDTH'(r_mx[NORM_WIDTH-1:0]);
                    n_mp  = UNIT_WIDTH'(r_mx[NORM_WIDTH-1:0]);
                    n_acc = '0;
                    n_cnt = CNT_WIDTH'(UNIT_WIDTH - 1);
                    n_state = S_SQX;
                end
            end
            S_SQX, S_SQY, S_MOX, S_MOY: begin
                // shift-add multiply, one multiplier bit a cycle
                if (r_mp[0]) n_acc = r_acc + r_mc;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - 1'b1;
                rnd   = {1'b0, n_acc} + (MAC_WIDTH+1)'(1 << (UNIT_SHIFT - 1));
                if (r_cnt == '0) begin
                    n_cnt = CNT_WIDTH'(UNIT_WIDTH - 1);
                    case (r_state)
                        S_SQX: begin
                            n_mc = MAC_WIDTH'(r_my[NORM_WIDTH-1:0]);
                            n_mp = UNIT_WIDTH'(r_my[NORM_WIDTH-1:0]);
                            n_state = S_SQY;
                        end
                        S_SQY: begin
                            n_root = '0;
                            n_state = S_SQRT;
                        end
                        S_MOX: begin
                            n_offx = rnd[MAC_WIDTH-1:UNIT_SHIFT];
                            n_mc  = MAC_WIDTH'(r_ux);
                            n_mp  = dmag;
                            n_acc = '0;
                            n_state = S_MOY;
                        end
                        default: begin
                            n_offy = rnd[MAC_WIDTH-1:UNIT_SHIFT];
                            n_state = S_PLACE;
                        end
                    endcase
                end
            end
            S_SQRT: begin
                // two radicand bits a cycle
                if (r_acc >= trial) begin
                    n_acc  = r_acc - trial;
                    n_root = (r_root >> 1) + bitv;
                end else begin
                    n_root = r_root >> 1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_len = n_root[UNIT_WIDTH-1:0];
                    n_num = (NUM_WIDTH'(r_mx[NORM_WIDTH-1:0]) << UNIT_SHIFT)
                          + NUM_WIDTH'(n_root[UNIT_WIDTH-1:1]);
                    n_rem = '0;
                    n_quo = '0;
                    n_cnt = CNT_WIDTH'(NUM_WIDTH - 1);
                    n_state = S_DIVX;
                end
            end
            S_DIVX, S_DIVY: begin
                if (tdiv >= {1'b0, r_len}) begin
                    n_rem = UNIT_WIDTH'(tdiv - {1'b0, r_len});
                    n_quo = {r_quo[UNIT_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = tdiv[UNIT_WIDTH-1:0];
                    n_quo = {r_quo[UNIT_WIDTH-2:0], 1'b0};
                end
                n_num = r_num << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_state == S_DIVX) begin
                        n_ux  = n_quo;
                        n_num = (NUM_WIDTH'(r_my[NORM_WIDTH-1:0]) << UNIT_SHIFT)
                              + NUM_WIDTH'(r_len[UNIT_WIDTH-1:1]);
                        n_rem = '0;
                        n_quo = '0;
                        n_cnt = CNT_WIDTH'(NUM_WIDTH - 1);
                        n_state = S_DIVY;
                    end else begin
                        n_uy = n_quo;
                        n_state = S_UDONE;
                    end
                end
            end
            S_UDONE: begin
                unique case (r_job)
                    J_A: begin
                        n_sx = r_ux;  n_sxn = ex_n;
                        n_sy = r_uy;  n_syn = ey_n;
                        ld_en = 1'b1;
                        ld_xn = d_cp_x[W];  ld_xm = MW'(d_cp_x[W-1:0]);
                        ld_yn = d_cp_y[W];  ld_ym = MW'(d_cp_y[W-1:0]);
                        n_job = J_B;
                    end
                    J_B: begin
                        ld_en = 1'b1;
                        ld_xn = sa_x[UNIT_WIDTH];  ld_xm = MW'(sa_x[UNIT_WIDTH-1:0]);
                        ld_yn = sa_y[UNIT_WIDTH];  ld_ym = MW'(sa_y[UNIT_WIDTH-1:0]);
                        n_job = J_P;
                    end
                    default: begin
                        if (r_uzero) begin
                            n_stg_x = raw_x;  n_stg_y = raw_y;
                            n_stg_deg = 1'b1;  n_stg_eol = (r_job == J_C);
                            n_state = S_OUT;
                        end else begin
                            n_mc  = MAC_WIDTH'(r_uy);
                            n_mp  = dmag;
                            n_acc = '0;
                            n_cnt = CNT_WIDTH'(UNIT_WIDTH - 1);
                            n_state = S_MOX;
                        end
                    end
                endcase
            end
            S_PLACE: begin
                // left normal: x moves by -uy*D, y by ux*D
                n_stg_x = f_place(raw_x, (!ey_n) ^ dneg, r_offx);
                n_stg_y = f_place(raw_y, ex_n ^ dneg, r_offy);
                n_stg_deg = 1'b0;
                n_stg_eol = (r_job == J_C);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ox = r_stg_x;  n_oy = r_stg_y;
                    n_odeg = r_stg_deg;  n_oeol = r_stg_eol;
                    if (r_job == J_P && r_fin) begin
                        ld_en = 1'b1;
                        ld_xn = d_cp_x[W];  ld_xm = MW'(d_cp_x[W-1:0]);
                        ld_yn = d_cp_y[W];  ld_ym = MW'(d_cp_y[W-1:0]);
                        n_job = J_C;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                // advance the vertex history
                if (r_fin) begin
                    n_seen = 2'd0;
                end else if (r_seen == 2'd0) begin
                    n_pri_x = r_cur_x;  n_pri_y = r_cur_y;
                    n_seen = 2'd1;
                end else begin
                    n_old_x = r_pri_x;  n_old_y = r_pri_y;
                    n_pri_x = r_cur_x;  n_pri_y = r_cur_y;
                    n_seen = 2'd2;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (ld_en) begin
            n_mx = ld_xm;  n_nx = ld_xn;
            n_my = ld_ym;  n_ny = ld_yn;
            n_ux = '0;     n_uy = '0;
            n_uzero = (ld_xm == '0) && (ld_ym == '0);
            n_state = n_uzero ? S_UDONE : S_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= J_A;
            r_cnt   <= '0;
            r_seen  <= 2'd0;
            r_fin   <= 1'b0;
            r_dist  <= '0;
            r_pri_x <= '0;  r_pri_y <= '0;
            r_old_x <= '0;  r_old_y <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_fin   <= n_fin;
            r_dist  <= n_dist;
            r_pri_x <= n_pri_x;  r_pri_y <= n_pri_y;
            r_old_x <= n_old_x;  r_old_y <= n_old_y;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;  r_cur_y <= n_cur_y;
        r_mx <= n_mx;  r_my <= n_my;  r_nx <= n_nx;  r_ny <= n_ny;  r_uzero <= n_uzero;
        r_mc <= n_mc;  r_acc <= n_acc;  r_root <= n_root;  r_mp <= n_mp;
        r_num <= n_num;  r_rem <= n_rem;  r_quo <= n_quo;  r_len <= n_len;
        r_ux <= n_ux;  r_uy <= n_uy;  r_sx <= n_sx;  r_sy <= n_sy;
        r_sxn <= n_sxn;  r_syn <= n_syn;
        r_offx <= n_offx;  r_offy <= n_offy;
        r_stg_x <= n_stg_x;  r_stg_y <= n_stg_y;
        r_stg_deg <= n_stg_deg;  r_stg_eol <= n_stg_eol;
        r_ox <= n_ox;  r_oy <= n_oy;  r_odeg <= n_odeg;  r_oeol <= n_oeol;
    end

endmodule

@@ sv/pvo_checker.sv @@
// Port-level checks for polyline_vertex_offset, attached by bind.
// Depends on pvo_pkg and the top level's ports.
module pvo_checker
    import pvo_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [COORD_WIDTH-1:0] i_ox,
    input logic [COORD_WIDTH-1:0] i_oy,
    input logic                   i_odeg,
    input logic                   i_oeol
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_ox) && $stable(i_oy) && $stable(i_odeg) && $stable(i_oeol))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one request at a time: the sequencer leaves idle on every request
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

endmodule

bind polyline_vertex_offset pvo_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pvo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_ox        (o_res.ox),
    .i_oy        (o_res.oy),
    .i_odeg      (o_res.degenerate),
    .i_oeol      (o_res.end_of_line)
);
